// ----- sv/hsv2rgb_pkg.sv -----
// Shared types, widths and helpers for the HSV to RGB converter pipeline.
// No dependencies; every other file refers to this package by scoped name.

package hsv2rgb_pkg;

  // Fixed-point format: 1.0 equals 2^FRAC_BITS. Port fields are fixed at 17 bits.
  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 17;
  // Internal value width: holds 1.0 itself, or any raw field when 1.0 is wider.
  localparam int IW        = FRAC_BITS + 1;
  // Common width for comparing a raw field against 1.0.
  localparam int CW        = (IW > FIELD_W) ? IW : FIELD_W;

  localparam logic [IW-1:0] ONE = IW'(1) << FRAC_BITS;

  // Hue sectors, named by the two primaries/secondaries they span.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_t;

  // After clamping and hue split.
  typedef struct packed {
    sector_t             sector;
    logic [FRAC_BITS-1:0] frac;
    logic [IW-1:0]       sat;
    logic [IW-1:0]       val;
  } split_t;

  // After the first row of products.
  typedef struct packed {
    sector_t       sector;
    logic [IW-1:0] val;
    logic [IW-1:0] a;
    logic [IW-1:0] fs;
    logic [IW-1:0] sf;
  } prod_t;

  // All three candidate levels, ready for sector routing.
  typedef struct packed {
    sector_t       sector;
    logic [IW-1:0] val;
    logic [IW-1:0] a;
    logic [IW-1:0] b;
    logic [IW-1:0] c;
  } level_t;

  // Saturate a raw field to 1.0.
  function automatic logic [IW-1:0] clamp_one(input logic [FIELD_W-1:0] x);
    logic [CW-1:0] xe;
    xe = CW'(x);
    if (xe > CW'(ONE)) begin
      return ONE;
    end
    return xe[IW-1:0];
  endfunction

  // Fit an internal value into a port field (zero-extend or mask).
  function automatic logic [FIELD_W-1:0] to_field(input logic [IW-1:0] x);
    logic [CW-1:0] xe;
    xe = CW'(x);
    return xe[FIELD_W-1:0];
  endfunction

endpackage

// ----- sv/hsv2rgb_split.sv -----
// First pipeline stage: saturate inputs to 1.0, scale hue by six and split it
// into sector and fraction. Depends on hsv2rgb_pkg.

module hsv2rgb_split (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_stall,
  input  hsv2rgb_pkg::hsv_t   up,
  output logic                dn_valid,
  input  logic                dn_stall,
  output hsv2rgb_pkg::split_t dn
);

  logic                              vld;
  logic                              adv;
  logic [hsv2rgb_pkg::IW-1:0]        h;
  logic [hsv2rgb_pkg::IW+1:0]        h6;
  logic [2:0]                        sec_raw;
  hsv2rgb_pkg::split_t               dn_next;

  assign adv      = !vld || !dn_stall;
  assign up_stall = !adv;
  assign dn_valid = vld;

  always_comb begin
    h       = hsv2rgb_pkg::clamp_one(up.hue);
    // h * 6 as 4h + 2h
    h6      = {h, 2'b00} + {1'b0, h, 1'b0};
    sec_raw = h6[hsv2rgb_pkg::FRAC_BITS+2:hsv2rgb_pkg::FRAC_BITS];
    // full hue lands on sector six: wrap to the red sector
    dn_next.sector = (sec_raw >= 3'd6) ? hsv2rgb_pkg::SEC_RED_YEL
                                       : hsv2rgb_pkg::sector_t'(sec_raw);
    dn_next.frac   = h6[hsv2rgb_pkg::FRAC_BITS-1:0];
    dn_next.sat    = hsv2rgb_pkg::clamp_one(up.saturation);
    dn_next.val    = hsv2rgb_pkg::clamp_one(up.brightness);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// ----- sv/hsv2rgb_prod.sv -----
// Second pipeline stage: f*s, s*(1-f) and the low level v*(1-s), all truncated.
// Depends on hsv2rgb_pkg.

module hsv2rgb_prod (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_stall,
  input  hsv2rgb_pkg::split_t up,
  output logic                dn_valid,
  input  logic                dn_stall,
  output hsv2rgb_pkg::prod_t  dn
);

  localparam int IW = hsv2rgb_pkg::IW;
  localparam int FB = hsv2rgb_pkg::FRAC_BITS;

  logic            vld;
  logic            adv;
  logic [IW-1:0]   f_ext;
  logic [IW-1:0]   one_minus_f;
  logic [IW-1:0]   one_minus_s;
  logic [2*IW-1:0] fs_p;
  logic [2*IW-1:0] sf_p;
  logic [2*IW-1:0] a_p;
  hsv2rgb_pkg::prod_t dn_next;

  assign adv      = !vld || !dn_stall;
  assign up_stall = !adv;
  assign dn_valid = vld;

  always_comb begin
    f_ext       = {1'b0, up.frac};
    one_minus_f = hsv2rgb_pkg::ONE - f_ext;
    one_minus_s = hsv2rgb_pkg::ONE - up.sat;
    fs_p        = (2*IW)'(f_ext) * (2*IW)'(up.sat);
    sf_p        = (2*IW)'(up.sat) * (2*IW)'(one_minus_f);
    a_p         = (2*IW)'(up.val) * (2*IW)'(one_minus_s);
    dn_next.sector = up.sector;
    dn_next.val    = up.val;
    dn_next.a      = a_p[FB+IW-1:FB];
    dn_next.fs     = fs_p[FB+IW-1:FB];
    dn_next.sf     = sf_p[FB+IW-1:FB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// ----- sv/hsv2rgb_ramp.sv -----
// Third pipeline stage: falling level v*(1-f*s) and rising level v*(1-s*(1-f)).
// Depends on hsv2rgb_pkg.

module hsv2rgb_ramp (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_stall,
  input  hsv2rgb_pkg::prod_t  up,
  output logic                dn_valid,
  input  logic                dn_stall,
  output hsv2rgb_pkg::level_t dn
);

  localparam int IW = hsv2rgb_pkg::IW;
  localparam int FB = hsv2rgb_pkg::FRAC_BITS;

  logic            vld;
  logic            adv;
  logic [IW-1:0]   one_minus_fs;
  logic [IW-1:0]   one_minus_sf;
  logic [2*IW-1:0] b_p;
  logic [2*IW-1:0] c_p;
  hsv2rgb_pkg::level_t dn_next;

  assign adv      = !vld || !dn_stall;
  assign up_stall = !adv;
  assign dn_valid = vld;

  always_comb begin
    one_minus_fs   = hsv2rgb_pkg::ONE - up.fs;
    one_minus_sf   = hsv2rgb_pkg::ONE - up.sf;
    b_p            = (2*IW)'(up.val) * (2*IW)'(one_minus_fs);
    c_p            = (2*IW)'(up.val) * (2*IW)'(one_minus_sf);
    dn_next.sector = up.sector;
    dn_next.val    = up.val;
    dn_next.a      = up.a;
    dn_next.b      = b_p[FB+IW-1:FB];
    dn_next.c      = c_p[FB+IW-1:FB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// ----- sv/hsv2rgb_route.sv -----
// Last pipeline stage and output register: route v, a, b, c to red, green and
// blue by hue sector. Depends on hsv2rgb_pkg.

module hsv2rgb_route (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_stall,
  input  hsv2rgb_pkg::level_t up,
  output logic                dn_valid,
  input  logic                dn_stall,
  output hsv2rgb_pkg::rgb_t   dn
);

  localparam int IW = hsv2rgb_pkg::IW;

  logic          vld;
  logic          adv;
  logic [IW-1:0] r;
  logic [IW-1:0] g;
  logic [IW-1:0] bl;
  hsv2rgb_pkg::rgb_t dn_next;

  assign adv      = !vld || !dn_stall;
  assign up_stall = !adv;
  assign dn_valid = vld;

  always_comb begin
    case (up.sector)
      hsv2rgb_pkg::SEC_RED_YEL: begin r = up.val; g = up.c;   bl = up.a;   end
      hsv2rgb_pkg::SEC_YEL_GRN: begin r = up.b;   g = up.val; bl = up.a;   end
      hsv2rgb_pkg::SEC_GRN_CYN: begin r = up.a;   g = up.val; bl = up.c;   end
      hsv2rgb_pkg::SEC_CYN_BLU: begin r = up.a;   g = up.b;   bl = up.val; end
      hsv2rgb_pkg::SEC_BLU_MAG: begin r = up.c;   g = up.a;   bl = up.val; end
      default:                  begin r = up.val; g = up.a;   bl = up.b;   end
    endcase
    dn_next.red   = hsv2rgb_pkg::to_field(r);
    dn_next.green = hsv2rgb_pkg::to_field(g);
    dn_next.blue  = hsv2rgb_pkg::to_field(bl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      dn <= dn_next;
    end
  end

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// HSV to RGB converter, top level: chains the split, product, ramp and route stages.
// Depends on hsv2rgb_pkg and the four hsv2rgb_* stage modules.

// Converts one color request per clock, when the output is not stalled, from hue,
// saturation and value to red, green and blue, all unsigned fixed point with
// 1.0 at 2^FRAC_BITS (17-bit fields). Inputs above 1.0 are saturated to 1.0,
// and a hue of exactly 1.0 wraps to the red sector. Throughput is one request
// per cycle while rgb_stall is low. The accepting edge loads the first of four
// register stages (clamp and hue split), and the later stages follow in order:
// the first row of 17x17 products, the second row of products, and sector
// routing into the output register. Each stage holds its own valid bit and
// advances whenever it is empty or its successor takes its data, so a stalled
// output only backs up as far as it must and bubbles are squeezed out.
// hsv_stall depends combinationally on rgb_stall through that chain. Zero
// saturation needs no special path: every level then equals value, which
// gives grey.

module hsv_to_rgb_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              hsv_valid,
  output logic              hsv_stall,
  input  hsv2rgb_pkg::hsv_t hsv,
  output logic              rgb_valid,
  input  logic              rgb_stall,
  output hsv2rgb_pkg::rgb_t rgb
);

  // Handshake between stages: valid forward, stall backward.
  logic                split_valid;
  logic                split_stall;
  hsv2rgb_pkg::split_t split_data;

  logic                prod_valid;
  logic                prod_stall;
  hsv2rgb_pkg::prod_t  prod_data;

  logic                ramp_valid;
  logic                ramp_stall;
  hsv2rgb_pkg::level_t ramp_data;

  // Stage 1: saturate, scale hue by six, split sector and fraction.
  hsv2rgb_split u_split (
    .clk      (clk),
    .rst      (rst),
    .up_valid (hsv_valid),
    .up_stall (hsv_stall),
    .up       (hsv),
    .dn_valid (split_valid),
    .dn_stall (split_stall),
    .dn       (split_data)
  );

  // Stage 2: f*s, s*(1-f) and the low level v*(1-s).
  hsv2rgb_prod u_prod (
    .clk      (clk),
    .rst      (rst),
    .up_valid (split_valid),
    .up_stall (split_stall),
    .up       (split_data),
    .dn_valid (prod_valid),
    .dn_stall (prod_stall),
    .dn       (prod_data)
  );

  // Stage 3: falling and rising levels scaled by value.
  hsv2rgb_ramp u_ramp (
    .clk      (clk),
    .rst      (rst),
    .up_valid (prod_valid),
    .up_stall (prod_stall),
    .up       (prod_data),
    .dn_valid (ramp_valid),
    .dn_stall (ramp_stall),
    .dn       (ramp_data)
  );

  // Stage 4: route levels to channels by sector; this is the output register.
  hsv2rgb_route u_route (
    .clk      (clk),
    .rst      (rst),
    .up_valid (ramp_valid),
    .up_stall (ramp_stall),
    .up       (ramp_data),
    .dn_valid (rgb_valid),
    .dn_stall (rgb_stall),
    .dn       (rgb)
  );

endmodule

// ----- sv/hsv2rgb_checker.sv -----
// Port-level checks for the HSV to RGB converter, bound to its top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter.

module hsv2rgb_checker (
  input logic              clk,
  input logic              rst,
  input logic              hsv_valid,
  input logic              hsv_stall,
  input hsv2rgb_pkg::hsv_t hsv,
  input logic              rgb_valid,
  input logic              rgb_stall,
  input hsv2rgb_pkg::rgb_t rgb
);

  // Hold a stalled result.
  a_rgb_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
    else $error("stalled result dropped or changed");

  // An empty output register never pushes back on requests.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !rgb_valid |-> !hsv_stall)
    else $error("request stalled with an empty output stage");

  // With the output not stalled, an accepted request shows up as a valid result on the port.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall) ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
      |=> rgb_valid)
    else $error("result missing four cycles after request");

  // Zero saturation gives grey at the saturated brightness.
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall && hsv.saturation == '0)
      ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
      |=> rgb.red == $past(hsv2rgb_pkg::to_field(hsv2rgb_pkg::clamp_one(hsv.brightness)), 4)
       && rgb.green == rgb.red && rgb.blue == rgb.red)
    else $error("zero saturation did not give grey");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst       (rst),
  .hsv_valid (hsv_valid),
  .hsv_stall (hsv_stall),
  .hsv       (hsv),
  .rgb_valid (rgb_valid),
  .rgb_stall (rgb_stall),
  .rgb       (rgb)
);

// ----- tb/hsv_to_rgb_converter_tb.sv -----
// Self-checking testbench for hsv_to_rgb_converter: directed color probes, then random colors,
// with random idling on both channels and one long output hold-off to back up the pipeline.
// Depends on hsv2rgb_pkg for the port structs, field widths, fraction bits and sector codes.

module hsv_to_rgb_converter_tb;

  localparam int          N_RANDOM  = 1650;
  localparam int          HOLD_AT   = 400;  // requests sent before the long hold-off
  localparam int          HOLD_LEN  = 60;   // cycles of the long hold-off
  localparam int          DRAIN_LEN = 12;   // pipeline is four deep; allow a margin
  localparam logic [16:0] U1        = 17'h10000;  // 1.0
  localparam logic [16:0] FULL      = 17'h1FFFF;  // largest raw field

  localparam longint unsigned UNIT       = 64'd1 << hsv2rgb_pkg::FRAC_BITS;
  localparam longint unsigned FIELD_MASK = (64'd1 << hsv2rgb_pkg::FIELD_W) - 64'd1;

  logic              clk = 1'b0;
  logic              rst;
  logic              hsv_valid;
  logic              hsv_stall;
  hsv2rgb_pkg::hsv_t hsv;
  logic              rgb_valid;
  logic              rgb_stall;
  hsv2rgb_pkg::rgb_t rgb;

  hsv2rgb_pkg::rgb_t rgb_pending [$];  // expected colors, oldest first
  hsv2rgb_pkg::rgb_t rgb_want;
  int   errors  = 0;
  int   sent    = 0;
  bit   idle_en = 1'b1;

  // Directed probes. A typed row carries its expected color; the rest go through
  // the predictor.
  typedef struct {
    logic [16:0] h;
    logic [16:0] s;
    logic [16:0] v;
    bit          typed;
    logic [16:0] r;
    logic [16:0] g;
    logic [16:0] b;
  } probe_t;

  probe_t probes [0:19] = '{
    // black, greys and over-range value under zero saturation
    '{17'h00000, 17'h00000, 17'h00000, 1'b1, 17'h00000, 17'h00000, 17'h00000},
    '{17'h04000, 17'h00000, U1,        1'b1, U1,        U1,        U1       },
    '{17'h09000, 17'h00000, 17'h05A5A, 1'b1, 17'h05A5A, 17'h05A5A, 17'h05A5A},
    '{FULL,      17'h00000, FULL,      1'b1, U1,        U1,        U1       },
    // pure red, full hue wrapping back to red, everything over range, zero value
    '{17'h00000, U1,        U1,        1'b1, U1,        17'h00000, 17'h00000},
    '{U1,        U1,        U1,        1'b1, U1,        17'h00000, 17'h00000},
    '{FULL,      FULL,      FULL,      1'b1, U1,        17'h00000, 17'h00000},
    '{17'h0AAAA, U1,        17'h00000, 1'b1, 17'h00000, 17'h00000, 17'h00000},
    // one probe per sector
    '{17'h01000, 17'h08000, 17'h0C000, 1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h03800, 17'h0C000, 17'h0F000, 1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h06000, 17'h04000, 17'h0A000, 1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h08800, 17'h0E000, U1,        1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h0B000, 17'h0FFFF, 17'h07FFF, 1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h0E000, 17'h05555, 17'h0AAAA, 1'b0, 17'h0,     17'h0,     17'h0    },
    // sector edges, smallest saturation, values just past 1.0
    '{17'h0FFFF, U1,        17'h0FFFF, 1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h02AAB, 17'h00001, U1,        1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h05556, U1,        U1,        1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h10001, 17'h12345, 17'h0FFFF, 1'b0, 17'h0,     17'h0,     17'h0    },
    '{17'h0AAAA, 17'h1FFFE, 17'h15555, 1'b0, 17'h0,     17'h0,     17'h0    },
    '{FULL,      17'h00001, 17'h00001, 1'b0, 17'h0,     17'h0,     17'h0    }
  };

  logic [16:0] corners [0:6] = '{17'h00000, 17'h00001, 17'h0FFFF, U1, 17'h10001,
                                 17'h15555, FULL};

  hsv_to_rgb_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  always #6 clk = ~clk;

  // Saturate a raw field to 1.0; when 1.0 is wider than the field nothing saturates.
  function automatic longint unsigned limit_unit(input logic [16:0] x);
    longint unsigned xv;
    xv = 64'(x) & FIELD_MASK;
    return (xv > UNIT) ? UNIT : xv;
  endfunction

  // Fixed-point product, truncated.
  function automatic longint unsigned fx_mul(input longint unsigned x, input longint unsigned y);
    return (x * y) >> hsv2rgb_pkg::FRAC_BITS;
  endfunction

  // Expected color for one request: six-sector conversion with truncated products.
  function automatic hsv2rgb_pkg::rgb_t convert_hsv(input hsv2rgb_pkg::hsv_t col);
    longint unsigned      h, s, v, h6, f, lo, fall, rise, r, g, b;
    hsv2rgb_pkg::sector_t sec;
    hsv2rgb_pkg::rgb_t    o;
    h = limit_unit(col.hue);
    s = limit_unit(col.saturation);
    v = limit_unit(col.brightness);
    if (s == 0) begin
      // grey
      r = v;
      g = v;
      b = v;
    end else begin
      h6   = h * 6;
      f    = h6 & (UNIT - 1);
      lo   = fx_mul(v, UNIT - s);
      fall = fx_mul(v, UNIT - fx_mul(f, s));
      rise = fx_mul(v, UNIT - fx_mul(s, UNIT - f));
      // a full hue lands in sector six, which is red again
      if ((h6 >> hsv2rgb_pkg::FRAC_BITS) >= 6) begin
        sec = hsv2rgb_pkg::SEC_RED_YEL;
      end else begin
        sec = hsv2rgb_pkg::sector_t'(3'(h6 >> hsv2rgb_pkg::FRAC_BITS));
      end
      case (sec)
        hsv2rgb_pkg::SEC_RED_YEL: begin r = v;    g = rise; b = lo;   end
        hsv2rgb_pkg::SEC_YEL_GRN: begin r = fall; g = v;    b = lo;   end
        hsv2rgb_pkg::SEC_GRN_CYN: begin r = lo;   g = v;    b = rise; end
        hsv2rgb_pkg::SEC_CYN_BLU: begin r = lo;   g = fall; b = v;    end
        hsv2rgb_pkg::SEC_BLU_MAG: begin r = rise; g = lo;   b = v;    end
        default:                  begin r = v;    g = lo;   b = fall; end
      endcase
    end
    o.red   = 17'(r & FIELD_MASK);
    o.green = 17'(g & FIELD_MASK);
    o.blue  = 17'(b & FIELD_MASK);
    return o;
  endfunction

  task automatic check_field(input string name, input logic [16:0] want, input logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Offer one request, with an optional idle burst ahead of it, and record the
  // expected color once the converter takes it. Valid stays high between
  // back-to-back requests, so it gets one assignment per step.
  task automatic send_color(input hsv2rgb_pkg::hsv_t col, input bit typed,
                            input hsv2rgb_pkg::rgb_t want);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      hsv_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    hsv_valid <= 1'b1;
    hsv       <= col;
    // Read stall right after the edge: it still shows what that edge sampled.
    do @(posedge clk); while (hsv_stall);
    rgb_pending = {rgb_pending, typed ? want : convert_hsv(col)};
    sent++;
  endtask

  // Stimulus: reset, directed probes, random colors, then drain.
  initial begin
    hsv2rgb_pkg::hsv_t col;
    hsv2rgb_pkg::rgb_t want;
    int                pick;
    rst       <= 1'b1;
    hsv_valid <= 1'b0;
    hsv       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      col.hue        = probes[i].h;
      col.saturation = probes[i].s;
      col.brightness = probes[i].v;
      want.red       = probes[i].r;
      want.green     = probes[i].g;
      want.blue      = probes[i].b;
      send_color(col, probes[i].typed, want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // one quiet stretch in the middle, and a quiet tail
      idle_en = !((n >= 700 && n < 850) || n >= N_RANDOM - 200);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // in range: the bulk of real traffic
        col.hue        = 17'($urandom_range(0, 65536));
        col.saturation = 17'($urandom_range(0, 65536));
        col.brightness = 17'($urandom_range(0, 65536));
      end else if (pick < 8) begin
        // anywhere in the raw field, over-range included
        col.hue        = 17'($urandom_range(0, 17'h1FFFF));
        col.saturation = 17'($urandom_range(0, 17'h1FFFF));
        col.brightness = 17'($urandom_range(0, 17'h1FFFF));
      end else begin
        // corners, mixed with random fields
        col.hue        = corners[$urandom_range(0, 6)];
        col.saturation = ($urandom_range(0, 2) == 0) ? 17'h0 : corners[$urandom_range(0, 6)];
        col.brightness = ($urandom_range(0, 1) == 0) ? corners[$urandom_range(0, 6)]
                                                     : 17'($urandom_range(0, 65536));
      end
      send_color(col, 1'b0, '0);
    end
    hsv_valid <= 1'b0;

    // Drain whatever is still in flight, then give the pipeline time to show
    // any stray result.
    while (rgb_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    if (errors == 0 && rgb_pending.size() == 0) begin
      $display("hsv_to_rgb_converter_tb: clean");
    end else begin
      $display("hsv_to_rgb_converter_tb: errors");
    end
    $finish;
  end

  // Output side: short random stall bursts, plus one long hold-off once enough
  // requests have gone in, so the pipeline fills and stalls its input.
  initial begin
    bit held;
    held = 1'b0;
    rgb_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent >= HOLD_AT) begin
        held = 1'b1;
        rgb_stall <= 1'b1;
        for (int c = 0; c < HOLD_LEN; c++) @(posedge clk);
        rgb_stall <= 1'b0;
      end else if (idle_en && !rst && $urandom_range(0, 4) == 0) begin
        rgb_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        rgb_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted color with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rgb_valid && !rgb_stall) begin
      if (rgb_pending.size() == 0) begin
        $display("%0t: color expected none got %h", $time, rgb);
        errors++;
      end else begin
        rgb_want = rgb_pending.pop_front();
        check_field("red", rgb_want.red, rgb.red);
        check_field("green", rgb_want.green, rgb.green);
        check_field("blue", rgb_want.blue, rgb.blue);
      end
    end
  end

  // Guard against a hung handshake.
  initial begin
    #(12 * 300000);
    $display("hsv_to_rgb_converter_tb: errors");
    $finish;
  end

endmodule
